// ===== rtl/u2u_pkg.sv =====
package u2u_pkg;

  // Depth of the result queue; at least two so a byte can leave two units
  localparam int unsigned ResultDepth = 4;

  // Following bytes expected after a lead byte
  localparam logic [1:0] NoneOpen     = 2'd0;
  localparam logic [1:0] TwoByteLead  = 2'd1;
  localparam logic [1:0] ThreeByteLead = 2'd2;

  // Results produced by one input byte, handed from decoder to queue
  typedef struct packed {
    logic        emit_unit;  // a decoded code unit is produced
    logic [15:0] unit;       // its value
    logic        emit_term;  // the terminator follows (end of buffer)
  } dec_res_t;

  // One queued result
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } entry_t;

endpackage

// ===== rtl/u2u_dec.sv =====
module u2u_dec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_buffer_i,
  output u2u_pkg::dec_res_t  res_o
);

  logic [1:0]  pend_q, pend_d;
  logic [15:0] pv_q, pv_d;
  logic [15:0] shifted;

  // Decode of one byte against the open sequence
  always_comb begin
    res_o   = '0;
    pend_d  = pend_q;
    pv_d    = pv_q;
    shifted = {pv_q[9:0], in_byte_i[5:0]};
    if (pend_q != u2u_pkg::NoneOpen) begin
      // following byte: take low six bits, top bits not checked
      pv_d   = shifted;
      pend_d = pend_q - 2'd1;
      if (pend_d == u2u_pkg::NoneOpen) begin
        res_o.emit_unit = 1'b1;
        res_o.unit      = shifted;
        pv_d            = '0;
      end
    end else if (!in_byte_i[7]) begin
      res_o.emit_unit = 1'b1;
      res_o.unit      = {9'd0, in_byte_i[6:0]};
    end else if (in_byte_i[7:4] == 4'hF) begin
      // four-byte or longer lead: skipped
    end else if (in_byte_i[7:5] == 3'b111) begin
      pv_d   = {12'd0, in_byte_i[3:0]};
      pend_d = u2u_pkg::ThreeByteLead;
    end else if (in_byte_i[7:6] == 2'b11) begin
      pv_d   = {11'd0, in_byte_i[4:0]};
      pend_d = u2u_pkg::TwoByteLead;
    end
    // stray continuation bytes fall through and are skipped

    // end of buffer drops any open sequence and adds the terminator
    if (end_of_buffer_i) begin
      pend_d          = u2u_pkg::NoneOpen;
      pv_d            = '0;
      res_o.emit_term = 1'b1;
    end
  end

  // Sequence state, updated only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= u2u_pkg::NoneOpen;
      pv_q   <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      pv_q   <= pv_d;
    end
  end

`ifndef SYNTHESIS
  // a three-byte lead opens at most two following bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q != 2'd3)
    else $error("u2u_dec: pending count out of range");

  // end of buffer closes any open sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_buffer_i |=> pend_q == u2u_pkg::NoneOpen && pv_q == 16'd0)
    else $error("u2u_dec: sequence still open after end of buffer");

  // the last following byte always closes the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && pend_q == u2u_pkg::TwoByteLead |=> pend_q == u2u_pkg::NoneOpen)
    else $error("u2u_dec: sequence not closed by its last byte");
`endif

endmodule

// ===== rtl/u2u_fifo.sv =====
module u2u_fifo #(
  parameter int unsigned Depth = u2u_pkg::ResultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u2u_pkg::dec_res_t  res_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        code_unit_o,
  output logic               last_unit_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u2u_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;
  u2u_pkg::entry_t first, second;

  // Entries to write: the unit first, then the terminator
  always_comb begin
    push_n = 2'd0;
    if (push_i) begin
      push_n = {1'b0, res_i.emit_unit} + {1'b0, res_i.emit_term};
    end
    first.unit  = res_i.emit_unit ? res_i.unit : 16'd0;
    first.last  = !res_i.emit_unit;
    second.unit = 16'd0;
    second.last = 1'b1;
  end

  assign wr_next = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
  assign pop     = out_valid_o && !out_stall_i;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_n == 2'd1) begin
      wr_ptr_d = wr_next;
    end else if (push_n == 2'd2) begin
      wr_ptr_d = (wr_next == LastPtr) ? '0 : wr_next + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_next] <= second;
    end
  end

  // Room for the worst case of two results, from registered state only
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign code_unit_o = mem_q[rd_ptr_q].unit;
  assign last_unit_o = mem_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("u2u_fifo: queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_n == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("u2u_fifo: count did not drop on pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop && push_n == 2'd2 |=> cnt_q == $past(cnt_q) + 2'd2)
    else $error("u2u_fifo: count did not rise by two");
`endif

endmodule

// ===== rtl/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 to 16-bit code unit decoder.
// Input channel: one byte per request on in_byte_i, with end_of_buffer_i set
// on the final byte of a buffer. Accepted when in_valid_i is high and
// in_stall_o is low.
// Output channel: code_unit_o / last_unit_o, taken when out_valid_o is high
// and out_stall_i is low. last_unit_o marks the zero terminator that follows
// the final byte of each buffer.
// Throughput: one byte per cycle. A byte yields zero, one or two units; with
// the receiver always ready, a byte that yields two units (unit plus
// terminator) puts its extra unit into the result queue, which absorbs it,
// so input stalls only when the queue cannot take two more units.
// A unit produced by a byte is written into the result queue when that byte
// is accepted and appears on the output once the units ahead of it are taken.
// in_stall_o comes from the queue fill level alone. When the receiver stalls,
// the head unit holds and the queue fills; input stalls once fewer than two
// slots are free.
// Reset: no sequence open, the queue empty, out_valid_o low.
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned ResultDepth = u2u_pkg::ResultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        last_unit_o
);

  logic              room;
  logic              accept;
  u2u_pkg::dec_res_t res;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  // Byte decode and sequence state
  u2u_dec u_dec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .res_o           (res)
  );

  // Result queue, which also drives the output
  u2u_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .last_unit_o (last_unit_o)
  );

endmodule

// ===== sim/utf8_to_utf16_decoder_unit_tb.sv =====
module utf8_to_utf16_decoder_unit_tb;

  // One byte request waiting for the driver
  typedef struct {
    logic [7:0] value;
    logic       eob;
    logic       drain_first;  // hold until all units due have come out
  } byte_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] code_unit_o;
  logic        last_unit_o;

  byte_req_t         requests_waiting[$];
  u2u_pkg::entry_t   units_due[$];

  // Decoder state as predicted
  logic [1:0]  open_count = u2u_pkg::NoneOpen;
  logic [15:0] gathered = '0;

  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  utf8_to_utf16_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_unit_o    (code_unit_o),
    .last_unit_o    (last_unit_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Random idling on both sides, switched off for a stretch of the run
  function automatic bit take_break();
    if (bytes_accepted >= 400 && bytes_accepted < 650) return 1'b0;
    return $urandom_range(99) < 32;
  endfunction

  // Expected units for one accepted byte
  function automatic void decode_byte(logic [7:0] b, logic eob);
    if (open_count != u2u_pkg::NoneOpen) begin
      // any byte continues an open sequence, top bits ignored
      gathered   = {gathered[9:0], b[5:0]};
      open_count = open_count - 2'd1;
      if (open_count == u2u_pkg::NoneOpen) begin
        units_due.push_back('{unit: gathered, last: 1'b0});
        gathered = '0;
      end
    end else if (!b[7]) begin
      units_due.push_back('{unit: {8'h00, b}, last: 1'b0});
    end else if (b[7:4] == 4'hF) begin
      // four-byte and longer leads are skipped
    end else if (b[7:5] == 3'b111) begin
      gathered   = {12'h000, b[3:0]};
      open_count = u2u_pkg::ThreeByteLead;
    end else if (b[7:6] == 2'b11) begin
      gathered   = {11'h000, b[4:0]};
      open_count = u2u_pkg::TwoByteLead;
    end
    // a stray continuation byte falls through and is skipped

    if (eob) begin
      // terminator; a truncated tail is dropped
      open_count = u2u_pkg::NoneOpen;
      gathered   = '0;
      units_due.push_back('{unit: 16'h0000, last: 1'b1});
    end
  endfunction

  // Driver: present requests from the queue, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    logic      busy;
    byte_req_t req;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      in_byte_i       <= 8'h00;
      end_of_buffer_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_byte_i, end_of_buffer_i);
        bytes_accepted++;
        busy = 1'b0;
      end
      if (!busy && requests_waiting.size() != 0 && !take_break() &&
          (!requests_waiting[0].drain_first || units_due.size() == 0)) begin
        req = requests_waiting.pop_front();
        in_byte_i       <= req.value;
        end_of_buffer_i <= req.eob;
        busy = 1'b1;
      end
      in_valid_i <= busy;
    end
  end

  // Monitor: check each accepted unit against the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin : check_units
    u2u_pkg::entry_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (units_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected unit, expected none, got %h last %b",
                   $time, code_unit_o, last_unit_o);
        end else begin
          want = units_due.pop_front();
          if (code_unit_o !== want.unit) begin
            mismatches++;
            $display("%0t: code_unit expected %h, got %h", $time, want.unit, code_unit_o);
          end
          if (last_unit_o !== want.last) begin
            mismatches++;
            $display("%0t: last_unit expected %b, got %b", $time, want.last, last_unit_o);
          end
        end
      end
      out_stall_i <= take_break();
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == 3000) begin
        $display("utf8_to_utf16_decoder_unit test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_byte(logic [7:0] value, logic eob, logic drain_first = 1'b0);
    requests_waiting.push_back('{value: value, eob: eob, drain_first: drain_first});
  endtask

  initial begin : run
    logic [7:0]  piece_buf[$];
    logic [7:0]  rnd;
    int unsigned r, n, total;
    bit          mid_drain_done;

    // Directed: ASCII extremes, then a terminator
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    // stray continuation and over-long leads are skipped
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b1);
    // two-byte extremes
    push_byte(8'hC0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // three-byte extremes
    push_byte(8'hE0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    // following bytes are not checked: ASCII and leads taken as payload
    push_byte(8'hC3, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'hF5, 1'b0);
    push_byte(8'hC0, 1'b0);
    // truncated tail, then a lead on the final byte
    push_byte(8'hE1, 1'b0);
    push_byte(8'h85, 1'b1);
    push_byte(8'hC5, 1'b1);
    // unit and terminator from the same byte
    push_byte(8'hC2, 1'b0);
    push_byte(8'hA9, 1'b1);

    // Random buffers, mostly well-formed sequences
    total = 0;
    mid_drain_done = 1'b0;
    while (total < 1225) begin
      piece_buf = {};
      n = $urandom_range(1, 12);
      while (piece_buf.size() < n) begin
        r   = $urandom_range(99);
        rnd = 8'($urandom());
        if (r < 30) begin
          piece_buf.push_back({1'b0, rnd[6:0]});
        end else if (r < 55) begin
          piece_buf.push_back({3'b110, rnd[4:0]});
          rnd = 8'($urandom());
          piece_buf.push_back({2'b10, rnd[5:0]});
        end else if (r < 80) begin
          piece_buf.push_back({4'b1110, rnd[3:0]});
          rnd = 8'($urandom());
          piece_buf.push_back({2'b10, rnd[5:0]});
          rnd = 8'($urandom());
          piece_buf.push_back({2'b10, rnd[5:0]});
        end else if (r < 92) begin
          piece_buf.push_back(rnd);
        end else begin
          // broken sequence: a lead with too few following bytes
          if (rnd[7]) begin
            piece_buf.push_back({4'b1110, rnd[3:0]});
            if (rnd[6]) piece_buf.push_back({2'b10, rnd[5:0]});
          end else begin
            piece_buf.push_back({3'b110, rnd[4:0]});
          end
        end
      end
      foreach (piece_buf[i]) begin
        push_byte(piece_buf[i], i == piece_buf.size() - 1,
                  i == 0 && (total == 0 || (total >= 800 && !mid_drain_done)));
      end
      if (total >= 800) mid_drain_done = 1'b1;
      total += piece_buf.size();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_waiting.size() != 0 || in_valid_i || units_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("utf8_to_utf16_decoder_unit test passed");
    end else begin
      $display("utf8_to_utf16_decoder_unit test failed");
    end
    $finish;
  end

endmodule
